>>> design/langton_ant_grid_stepper_macros.svh
// Assertion macros for the checker file of the ant grid stepper.
`ifndef LANGTON_ANT_GRID_STEPPER_MACROS_SVH
`define LANGTON_ANT_GRID_STEPPER_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define LANT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lant checker: implication failed");

// Next-cycle implication, quiet while reset is asserted
`define LANT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lant checker: next-cycle implication failed");

// Next-cycle implication that also holds across reset
`define LANT_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lant checker: reset behavior failed");

`endif

>>> design/lant_pkg.sv
// Shared types, field widths and codes for the ant grid stepper.
package lant_pkg;

    // Built grid size defaults
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    // Register value after reset, clamped to the built size by the top level
    localparam int REG_RESET_DIM  = 128;

    // Field widths
    localparam int CMD_W        = 2;
    localparam int COORD_W      = 7;
    localparam int COUNT_W      = 16;
    localparam int HEAD_W       = 2;
    localparam int BLACK_W      = 15;
    localparam int TOTAL_W      = 32;
    localparam int IN_DATA_W    = 32;
    localparam int OUT_FIELDS_W = 81;
    localparam int OUT_DATA_W   = 88;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 8;

    localparam logic [BLACK_W-1:0] BLACK_SAT = '1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // Headings
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd3;

    // Cell update request to the cell unit
    typedef struct packed {
        logic toggle;   // flip the cell, else load value
        logic value;
    } t_cell_op;

    // Cell unit status back to the sequencer
    typedef struct packed {
        logic old_bit;
        logic inc;      // cell went white to black
        logic dec;      // cell went black to white
    } t_cell_stat;

endpackage

>>> design/lant_ram.sv
// Generic single-port RAM with registered read data.
module lant_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lant_cell_unit.sv
// Row read-modify-write unit: selects one cell of a grid row and updates it.
module lant_cell_unit import lant_pkg::*; #(
    parameter int WIDTH = DEF_MAX_WIDTH
) (
    input  logic [WIDTH-1:0]         i_row,
    input  logic [$clog2(WIDTH)-1:0] i_col,
    input  t_cell_op                 i_op,
    output logic [WIDTH-1:0]         o_row,
    output t_cell_stat               o_stat
);

    logic old_bit;
    logic new_bit;

    // Pick the cell and form its new color
    assign old_bit = i_row[i_col];
    assign new_bit = i_op.toggle ? ~old_bit : i_op.value;

    // Merge the new color back into the row
    always_comb begin
        o_row        = i_row;
        o_row[i_col] = new_bit;
    end

    // Report the color change for the black count
    assign o_stat.old_bit = old_bit;
    assign o_stat.inc     = ~old_bit & new_bit;
    assign o_stat.dec     = old_bit & ~new_bit;

endmodule

>>> design/langton_ant_grid_stepper.sv
// Ant grid stepper top level: command sequencer around a row memory and cell unit.
//
//  channel  | direction | handshake                         | payload
//  ---------+-----------+-----------------------------------+-------------------------------
//  s_axis   | in        | i_s_axis_tvalid / o_s_axis_tready | tdata x,y,color,count; tuser cmd
//  m_axis   | out       | o_m_axis_tvalid / i_m_axis_tready | tdata result and ant state
//  cfg      | in        | i_cfg_we                          | i_cfg_addr, i_cfg_data
//
// A run does a row read, then a modify and write back, for each step, then hands over its result;
// write and read make one such pass, or go straight to the result when the cell lies outside the grid.
// Clear and every register write sweep all MAX_HEIGHT rows of the row memory, one row a cycle;
// after reset the same sweep runs before the first item is taken.
// The result waits in an output register; the next item is taken while it stalls,
// and that item finishes once the register is free.
module langton_ant_grid_stepper import lant_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // cell_x[6:0], cell_y[13:7], cell_in[14], step_count[30:15], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // cell_out[0], steps_done[16:1], ant_on_grid[17], ant_col[24:18], ant_row[31:25],
    // ant_heading[33:32], black_total[48:34], step_total[80:49], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int AWW  = $clog2(MAX_WIDTH + 1);
    localparam int AHW  = $clog2(MAX_HEIGHT + 1);
    localparam int KW   = (COORD_W > AWW) ? COORD_W : AWW;
    localparam int KHW  = (COORD_W > AHW) ? COORD_W : AHW;
    localparam int AMX  = (AWW > AHW) ? AWW : AHW;
    localparam int CFW  = (CFG_DATA_W > AMX) ? CFG_DATA_W : AMX;
    localparam int BW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int BCW  = (BW > BLACK_W) ? BW : BLACK_W;
    localparam int RST_W = (REG_RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : REG_RESET_DIM;
    localparam int RST_H = (REG_RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : REG_RESET_DIM;
    localparam int PAD_W = OUT_DATA_W - OUT_FIELDS_W;

    // Sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]              r_state;
    logic [AWW-1:0]          r_act_w;
    logic [AHW-1:0]          r_act_h;
    logic [CMD_W-1:0]        r_cmd;
    logic [COORD_W-1:0]      r_x;
    logic [COORD_W-1:0]      r_y;
    logic                    r_val;
    logic [COUNT_W-1:0]      r_left;
    logic [COUNT_W-1:0]      r_done;
    logic                    r_rd_bit;
    logic [CW-1:0]           r_col;
    logic [RW-1:0]           r_row;
    logic [HEAD_W-1:0]       r_head;
    logic                    r_on;
    logic [BW-1:0]           r_black;
    logic [TOTAL_W-1:0]      r_steps;
    logic [RW-1:0]           r_clr_row;
    logic                    r_clr_cmd;
    logic                    r_m_valid;
    logic [OUT_DATA_W-1:0]   r_m_data;

    // Input beat fields
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic               in_val;
    logic [COUNT_W-1:0] in_n;
    logic               in_inside;
    logic               in_accept;

    assign in_x   = i_s_axis_tdata[6:0];
    assign in_y   = i_s_axis_tdata[13:7];
    assign in_val = i_s_axis_tdata[14];
    assign in_n   = i_s_axis_tdata[30:15];
    assign in_inside = (KW'(in_x) < KW'(r_act_w)) && (KHW'(in_y) < KHW'(r_act_h));

    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_we;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Clamp the written dimension to 1..built maximum
    logic [CFW-1:0] cfg_ext;
    logic [AWW-1:0] cfg_w;
    logic [AHW-1:0] cfg_h;

    assign cfg_ext = CFW'(i_cfg_data);
    assign cfg_w = (cfg_ext == '0) ? AWW'(1) :
                   (cfg_ext > CFW'(MAX_WIDTH)) ? AWW'(MAX_WIDTH) : AWW'(cfg_ext);
    assign cfg_h = (cfg_ext == '0) ? AHW'(1) :
                   (cfg_ext > CFW'(MAX_HEIGHT)) ? AHW'(MAX_HEIGHT) : AHW'(cfg_ext);

    // Cell coordinates as memory indexes
    logic [KW-1:0]  x_ext;
    logic [KHW-1:0] y_ext;
    logic [CW-1:0]  x_idx;
    logic [RW-1:0]  y_idx;

    assign x_ext = KW'(r_x);
    assign y_ext = KHW'(r_y);
    assign x_idx = x_ext[CW-1:0];
    assign y_idx = y_ext[RW-1:0];

    // Row memory and cell unit
    logic                 ram_we;
    logic [RW-1:0]        ram_addr;
    logic [MAX_WIDTH-1:0] ram_wdata;
    logic [MAX_WIDTH-1:0] ram_rdata;
    logic [MAX_WIDTH-1:0] cu_row;
    logic [CW-1:0]        cu_col;
    t_cell_op             cu_op;
    t_cell_stat           cu_stat;
    logic                 is_run;

    assign is_run    = (r_cmd == CMD_RUN);
    assign ram_we    = (r_state == S_CLR) || ((r_state == S_MOD) && (r_cmd != CMD_READ));
    assign ram_addr  = (r_state == S_CLR) ? r_clr_row : (is_run ? r_row : y_idx);
    assign ram_wdata = (r_state == S_CLR) ? '0 : cu_row;
    assign cu_col    = is_run ? r_col : x_idx;
    assign cu_op.toggle = is_run;
    assign cu_op.value  = r_val;

    lant_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    lant_cell_unit #(
        .WIDTH (MAX_WIDTH)
    ) u_cell (
        .i_row  (ram_rdata),
        .i_col  (cu_col),
        .i_op   (cu_op),
        .o_row  (cu_row),
        .o_stat (cu_stat)
    );

    // Turn, then look for the edge ahead
    logic [HEAD_W-1:0] n_head;
    logic [AWW-1:0]    col_p1;
    logic [AHW-1:0]    row_p1;
    logic              leave;
    logic [BW-1:0]     n_black;

    assign n_head = cu_stat.old_bit ? (r_head + HEAD_W'(1)) : (r_head - HEAD_W'(1));
    assign col_p1 = AWW'(r_col) + AWW'(1);
    assign row_p1 = AHW'(r_row) + AHW'(1);
    assign leave  = ((n_head == HEAD_UP)    && (r_row == '0)) ||
                    ((n_head == HEAD_RIGHT) && (col_p1 >= r_act_w)) ||
                    ((n_head == HEAD_DOWN)  && (row_p1 >= r_act_h)) ||
                    ((n_head == HEAD_LEFT)  && (r_col == '0));
    assign n_black = r_black + BW'(cu_stat.inc) - BW'(cu_stat.dec);

    // Result fields
    logic [BCW-1:0]     black_ext;
    logic [BLACK_W-1:0] black_out;
    logic [KW-1:0]      col_ext;
    logic [KHW-1:0]     row_ext;
    logic               out_free;

    assign black_ext = BCW'(r_black);
    assign black_out = (black_ext > BCW'(BLACK_SAT)) ? BLACK_SAT : black_ext[BLACK_W-1:0];
    assign col_ext   = KW'(r_col);
    assign row_ext   = KHW'(r_row);
    assign out_free  = !r_m_valid || i_m_axis_tready;

    // Sequencer and ant state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_act_w   <= AWW'(RST_W);
            r_act_h   <= AHW'(RST_H);
            r_clr_row <= '0;
            r_clr_cmd <= 1'b0;
            r_m_valid <= 1'b0;
            r_cmd     <= CMD_RUN;
            r_left    <= '0;
            r_done    <= '0;
            r_rd_bit  <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_head    <= HEAD_UP;
            r_on      <= 1'b1;
            r_black   <= '0;
            r_steps   <= '0;
        end else begin
            // Raise the result as it is loaded, drop it once taken
            if ((r_state == S_OUT) && out_free && !i_cfg_we) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                // Take the dimension and restart the clearing sweep
                if (i_cfg_addr == CFG_GRID_WIDTH) begin
                    r_act_w <= cfg_w;
                end else begin
                    r_act_h <= cfg_h;
                end
                r_state   <= S_CLR;
                r_clr_row <= '0;
                r_clr_cmd <= (r_state == S_CLR) ? r_clr_cmd : 1'b0;
            end else begin
                case (r_state)
                    S_CLR: begin
                        r_clr_row <= r_clr_row + RW'(1);
                        if (r_clr_row == RW'(MAX_HEIGHT - 1)) begin
                            r_col   <= CW'(r_act_w >> 1);
                            r_row   <= RW'(r_act_h >> 1);
                            r_head  <= HEAD_UP;
                            r_on    <= 1'b1;
                            r_black <= '0;
                            r_steps <= '0;
                            r_state <= r_clr_cmd ? S_OUT : S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (in_accept) begin
                            r_cmd    <= i_s_axis_tuser;
                            r_x      <= in_x;
                            r_y      <= in_y;
                            r_val    <= in_val;
                            r_left   <= in_n;
                            r_done   <= '0;
                            r_rd_bit <= 1'b0;
                            case (i_s_axis_tuser)
                                CMD_RUN: begin
                                    r_state <= (r_on && (in_n != '0)) ? S_RD : S_OUT;
                                end
                                CMD_WRITE, CMD_READ: begin
                                    r_state <= in_inside ? S_RD : S_OUT;
                                end
                                default: begin
                                    r_clr_row <= '0;
                                    r_clr_cmd <= 1'b1;
                                    r_state   <= S_CLR;
                                end
                            endcase
                        end
                    end
                    S_RD: begin
                        r_state <= S_MOD;
                    end
                    S_MOD: begin
                        // A read leaves the cell and the black count alone
                        if (r_cmd != CMD_READ) begin
                            r_black <= n_black;
                        end
                        case (r_cmd)
                            CMD_RUN: begin
                                r_head <= n_head;
                                if (r_steps != '1) begin
                                    r_steps <= r_steps + TOTAL_W'(1);
                                end
                                if (leave) begin
                                    r_on    <= 1'b0;
                                    r_state <= S_OUT;
                                end else begin
                                    case (n_head)
                                        HEAD_UP:    r_row <= r_row - RW'(1);
                                        HEAD_RIGHT: r_col <= r_col + CW'(1);
                                        HEAD_DOWN:  r_row <= r_row + RW'(1);
                                        default:    r_col <= r_col - CW'(1);
                                    endcase
                                    r_done  <= r_done + COUNT_W'(1);
                                    r_left  <= r_left - COUNT_W'(1);
                                    r_state <= (r_left == COUNT_W'(1)) ? S_OUT : S_RD;
                                end
                            end
                            CMD_READ: begin
                                r_rd_bit <= cu_stat.old_bit;
                                r_state  <= S_OUT;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                    S_OUT: begin
                        // Hand the result over once the output register is free
                        if (out_free) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free && !i_cfg_we) begin
            r_m_data <= {{PAD_W{1'b0}}, r_steps, black_out, r_head,
                         row_ext[COORD_W-1:0], col_ext[COORD_W-1:0], r_on, r_done, r_rd_bit};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

>>> design/lant_checker.sv
// Port-level checker for the ant grid stepper, bound to the top level.
`include "langton_ant_grid_stepper_macros.svh"

module lant_checker import lant_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic in_beat;
    logic out_stall;
    logic run_moved;

    assign in_beat   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign run_moved = o_m_axis_tvalid && (o_m_axis_tdata[16:1] != '0);

    // One item at a time: the input closes right after a beat
    `LANT_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, in_beat, !o_s_axis_tready)
    // A stalled result holds
    `LANT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // A run that moved the ant reads no cell
    `LANT_ASSERT_IMP(a_run_no_read, i_clk, i_rst_n, run_moved, !o_m_axis_tdata[0])
    // Reset empties the output and starts the clearing sweep
    `LANT_ASSERT_NXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n,
        !o_m_axis_tvalid && !o_s_axis_tready)

endmodule

bind langton_ant_grid_stepper lant_checker u_lant_checker (.*);
